@@ design/ttr_pkg.sv @@
// Package for the trajectory time resampler.
// Holds beat types, controller states, command/status structs and fixed constants.
// No dependencies.
`default_nettype none
package ttr_pkg;

    localparam logic [31:0] TIME_STEP_RESET = 32'd6554;
    localparam int unsigned DIV_CNT_W       = 6;
    localparam logic [5:0]  K_DIV_STEPS     = 6'd33;
    localparam logic [5:0]  ALPHA_DIV_STEPS = 6'd32;

    typedef struct packed {
        logic [31:0]        point_time;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               final_point;
    } in_t;

    typedef struct packed {
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic               run_end;
        logic               clipped;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE, S_FIRST, S_KSTART, S_KDIV, S_KDONE, S_TSTEP, S_ASTART, S_ADIV,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_ROUND, S_EMIT, S_FIN
    } state_t;

    typedef enum logic [2:0] {
        MP_XLO, MP_XHI, MP_YLO, MP_YHI, MP_YFIN
    } mul_phase_t;

    typedef struct packed {
        logic       load_in;
        logic       first_emit;
        logic       k_start;
        logic       k_done;
        logic       t_step;
        logic       a_start;
        logic       mul_en;
        mul_phase_t mul_phase;
        logic       round;
        logic       sample_emit;
        logic       final_emit;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic div_busy;
        logic do_samples;
        logic last_sample;
        logic final_needed;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

@@ design/ttr_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// 32-bit divisor, 33-bit dividend shifted in MSB first, preloadable remainder.
// Depends on ttr_pkg.
`default_nettype none
module ttr_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [31:0]                  rem_init,
    input  wire logic [32:0]                  dividend,
    input  wire logic [ttr_pkg::DIV_CNT_W-1:0] count,
    input  wire logic [31:0]                  divisor,
    output logic                              busy,
    output logic [32:0]                       quotient,
    output logic [31:0]                       remainder
);

    logic [ttr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] dvd_reg, dvd_next;
    logic [32:0] q_reg, q_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] r_sh;
    logic [32:0] r_sub;
    logic        ge;

    assign r_sh  = {rem_reg, dvd_reg[32]};
    assign r_sub = r_sh - {1'b0, div_reg};
    assign ge    = r_sh >= {1'b0, div_reg};

    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        q_next   = q_reg;
        div_next = div_reg;
        if (start) begin
            cnt_next = count;
            rem_next = rem_init;
            dvd_next = dividend;
            q_next   = '0;
            div_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = ge ? r_sub[31:0] : r_sh[31:0];
            dvd_next = {dvd_reg[31:0], 1'b0};
            q_next   = {q_reg[31:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ design/ttr_datapath.sv @@
// Resampler datapath: state registers, divider, shared 33x16 multiplier,
// rounding, output register and the time_step register. Depends on ttr_pkg, ttr_div.
`default_nettype none
module ttr_datapath #(
    parameter int unsigned MAX_SAMPLES_PER_SEGMENT = 63
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire ttr_pkg::in_t  s_data,
    input  wire logic          cfg_valid,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          m_ready,
    output logic               m_valid,
    output ttr_pkg::out_t      m_data,
    input  wire ttr_pkg::cmd_t cmd,
    output ttr_pkg::sts_t      sts
);

    localparam int unsigned JW = $clog2(MAX_SAMPLES_PER_SEGMENT + 1);
    localparam logic [JW-1:0] MAX_J = JW'(MAX_SAMPLES_PER_SEGMENT);

    ttr_pkg::in_t  in_reg;
    ttr_pkg::out_t out_reg, out_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   time_step_reg;
    logic          started_reg;
    logic [31:0]   prev_time_reg;
    logic [31:0]   prev_x_reg, prev_y_reg;
    logic [32:0]   clk_reg;
    logic [31:0]   emitted_x_reg, emitted_y_reg;
    logic          clip_reg;
    logic [JW-1:0] emit_reg, jcnt_reg;
    logic          do_samples_reg;
    logic [33:0]   t_reg;
    logic [32:0]   magx_reg, magy_reg;
    logic          negx_reg, negy_reg;
    logic [48:0]   prod_reg;
    logic [63:0]   accx_reg, accy_reg;
    logic [31:0]   sx_reg, sy_reg;

    logic [31:0] step;
    logic        pt_ge_clk;
    logic [32:0] k_dividend;
    logic [31:0] seg;
    logic [31:0] dt;
    logic        div_start, div_busy;
    logic [31:0] div_rem_init;
    logic [32:0] div_dividend;
    logic [ttr_pkg::DIV_CNT_W-1:0] div_count;
    logic [31:0] div_divisor;
    logic [32:0] quotient;
    logic [31:0] remainder;
    logic [32:0] dx, dy;
    logic [32:0] mop;
    logic [15:0] aop;
    logic [63:0] rndx, rndy;
    logic [31:0] rx, ry;
    logic        k_clip;
    logic        sample_final;
    logic        out_load;

    assign step       = (time_step_reg == '0) ? 32'd1 : time_step_reg;
    assign pt_ge_clk  = {1'b0, in_reg.point_time} >= clk_reg;
    assign k_dividend = pt_ge_clk ? ({1'b0, in_reg.point_time} - clk_reg) : '0;
    assign seg        = in_reg.point_time - prev_time_reg;
    assign dt         = (t_reg < {2'b0, prev_time_reg}) ? '0
                      : 32'(t_reg - {2'b0, prev_time_reg});

    assign div_start    = cmd.k_start | cmd.a_start;
    assign div_rem_init = cmd.a_start ? {1'b0, dt[31:1]} : '0;
    assign div_dividend = cmd.a_start ? {dt[0], 32'b0} : k_dividend;
    assign div_count    = cmd.a_start ? ttr_pkg::ALPHA_DIV_STEPS : ttr_pkg::K_DIV_STEPS;
    assign div_divisor  = cmd.a_start ? seg : step;

    ttr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .rem_init  (div_rem_init),
        .dividend  (div_dividend),
        .count     (div_count),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign dx = {in_reg.point_x[31], in_reg.point_x} - {prev_x_reg[31], prev_x_reg};
    assign dy = {in_reg.point_y[31], in_reg.point_y} - {prev_y_reg[31], prev_y_reg};

    assign mop = (cmd.mul_phase == ttr_pkg::MP_XLO || cmd.mul_phase == ttr_pkg::MP_XHI)
               ? magx_reg : magy_reg;
    assign aop = (cmd.mul_phase == ttr_pkg::MP_XLO || cmd.mul_phase == ttr_pkg::MP_YLO)
               ? quotient[15:0] : quotient[31:16];

    assign rndx = accx_reg + 64'h4000_0000;
    assign rndy = accy_reg + 64'h4000_0000;
    assign rx   = rndx[62:31];
    assign ry   = rndy[62:31];

    assign k_clip = quotient > 33'(MAX_SAMPLES_PER_SEGMENT);
    assign sample_final = in_reg.final_point &&
        (sx_reg != in_reg.point_x || sy_reg != in_reg.point_y);

    assign out_load = cmd.first_emit | cmd.sample_emit | cmd.final_emit;

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            if (cmd.sample_emit) begin
                out_next.sample_x = sx_reg;
                out_next.sample_y = sy_reg;
                out_next.run_end  = (jcnt_reg == emit_reg) && !sample_final;
                out_next.clipped  = clip_reg;
            end else begin
                out_next.sample_x = in_reg.point_x;
                out_next.sample_y = in_reg.point_y;
                out_next.run_end  = 1'b1;
                out_next.clipped  = cmd.final_emit ? clip_reg : 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            time_step_reg <= ttr_pkg::TIME_STEP_RESET;
            started_reg   <= 1'b0;
            prev_time_reg <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            clk_reg       <= '0;
            emitted_x_reg <= '0;
            emitted_y_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                time_step_reg <= cfg_data;
            end
            if (cmd.first_emit) begin
                clk_reg <= {1'b0, in_reg.point_time};
            end else if (cmd.k_done && pt_ge_clk) begin
                clk_reg <= {1'b0, in_reg.point_time} - {1'b0, remainder};
            end
            if (cmd.first_emit || cmd.commit) begin
                started_reg   <= !in_reg.final_point;
                prev_time_reg <= in_reg.point_time;
                prev_x_reg    <= in_reg.point_x;
                prev_y_reg    <= in_reg.point_y;
            end
            if (cmd.sample_emit) begin
                emitted_x_reg <= sx_reg;
                emitted_y_reg <= sy_reg;
            end else if (cmd.first_emit || cmd.final_emit) begin
                emitted_x_reg <= in_reg.point_x;
                emitted_y_reg <= in_reg.point_y;
            end
        end
        out_reg <= out_next;
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.k_done) begin
            clip_reg       <= k_clip;
            emit_reg       <= k_clip ? MAX_J : quotient[JW-1:0];
            do_samples_reg <= (in_reg.point_time > prev_time_reg) && (quotient != '0);
            t_reg          <= {1'b0, clk_reg};
            jcnt_reg       <= '0;
            negx_reg       <= dx[32];
            negy_reg       <= dy[32];
            magx_reg       <= dx[32] ? (~dx + 33'd1) : dx;
            magy_reg       <= dy[32] ? (~dy + 33'd1) : dy;
        end
        if (cmd.t_step) begin
            t_reg    <= t_reg + {2'b0, step};
            jcnt_reg <= jcnt_reg + 1'b1;
        end
        if (cmd.mul_en) begin
            prod_reg <= mop * aop;
            unique case (cmd.mul_phase)
                ttr_pkg::MP_XLO:  ;
                ttr_pkg::MP_XHI:  accx_reg <= {15'b0, prod_reg};
                ttr_pkg::MP_YLO:  accx_reg <= accx_reg + {prod_reg[47:0], 16'b0};
                ttr_pkg::MP_YHI:  accy_reg <= {15'b0, prod_reg};
                ttr_pkg::MP_YFIN: accy_reg <= accy_reg + {prod_reg[47:0], 16'b0};
                default:          ;
            endcase
        end
        if (cmd.round) begin
            sx_reg <= prev_x_reg + (negx_reg ? (~rx + 32'd1) : rx);
            sy_reg <= prev_y_reg + (negy_reg ? (~ry + 32'd1) : ry);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign sts.started      = started_reg;
    assign sts.div_busy     = div_busy;
    assign sts.do_samples   = do_samples_reg;
    assign sts.last_sample  = jcnt_reg == emit_reg;
    assign sts.final_needed = in_reg.final_point &&
        (emitted_x_reg != in_reg.point_x || emitted_y_reg != in_reg.point_y);
    assign sts.out_free     = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

@@ design/ttr_ctrl.sv @@
// Resampler controller: sequences the per-point division, the per-sample
// division, multiply and rounding, and the output beats. Depends on ttr_pkg.
`default_nettype none
module ttr_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ttr_pkg::sts_t sts,
    output ttr_pkg::cmd_t      cmd
);

    ttr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ttr_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_phase = ttr_pkg::MP_XLO;
        s_ready       = 1'b0;
        unique case (state_reg)
            ttr_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = sts.started ? ttr_pkg::S_KSTART : ttr_pkg::S_FIRST;
                end
            end
            ttr_pkg::S_FIRST: begin
                if (sts.out_free) begin
                    cmd.first_emit = 1'b1;
                    state_next     = ttr_pkg::S_IDLE;
                end
            end
            ttr_pkg::S_KSTART: begin
                cmd.k_start = 1'b1;
                state_next  = ttr_pkg::S_KDIV;
            end
            ttr_pkg::S_KDIV: begin
                if (!sts.div_busy) begin
                    state_next = ttr_pkg::S_KDONE;
                end
            end
            ttr_pkg::S_KDONE: begin
                cmd.k_done = 1'b1;
                state_next = ttr_pkg::S_TSTEP;
            end
            ttr_pkg::S_TSTEP: begin
                if (sts.do_samples) begin
                    cmd.t_step = 1'b1;
                    state_next = ttr_pkg::S_ASTART;
                end else begin
                    state_next = ttr_pkg::S_FIN;
                end
            end
            ttr_pkg::S_ASTART: begin
                cmd.a_start = 1'b1;
                state_next  = ttr_pkg::S_ADIV;
            end
            ttr_pkg::S_ADIV: begin
                if (!sts.div_busy) begin
                    state_next = ttr_pkg::S_M0;
                end
            end
            ttr_pkg::S_M0: begin
                cmd.mul_en = 1'b1;
                state_next = ttr_pkg::S_M1;
            end
            ttr_pkg::S_M1: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = ttr_pkg::MP_XHI;
                state_next    = ttr_pkg::S_M2;
            end
            ttr_pkg::S_M2: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = ttr_pkg::MP_YLO;
                state_next    = ttr_pkg::S_M3;
            end
            ttr_pkg::S_M3: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = ttr_pkg::MP_YHI;
                state_next    = ttr_pkg::S_M4;
            end
            ttr_pkg::S_M4: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = ttr_pkg::MP_YFIN;
                state_next    = ttr_pkg::S_ROUND;
            end
            ttr_pkg::S_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ttr_pkg::S_EMIT;
            end
            ttr_pkg::S_EMIT: begin
                if (sts.out_free) begin
                    cmd.sample_emit = 1'b1;
                    state_next = sts.last_sample ? ttr_pkg::S_FIN : ttr_pkg::S_TSTEP;
                end
            end
            ttr_pkg::S_FIN: begin
                if (!sts.final_needed) begin
                    cmd.commit = 1'b1;
                    state_next = ttr_pkg::S_IDLE;
                end else if (sts.out_free) begin
                    cmd.final_emit = 1'b1;
                    cmd.commit     = 1'b1;
                    state_next     = ttr_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ttr_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/trajectory_time_resampler_top.sv @@
// Trajectory time resampler, top level.
// Instantiates ttr_ctrl and ttr_datapath; depends on ttr_pkg.
//
// Usage:
//   s_valid/s_ready/s_data carry trajectory points (time, x, y, final flag).
//   m_valid/m_ready/m_data carry result beats (x, y, run_end, clipped).
//   cfg_valid/cfg_ready/cfg_data write time_step; write only while idle.
//   One point is taken at a time; s_ready is high only between points.
//   First point of a trajectory: one beat, loaded once the output register is free;
//   the block then returns to idle and can take the next point.
//   Later points: the sample-count division (one quotient bit per cycle,
//   33 bits), then for each emitted sample the alpha division, the
//   multiply/accumulate states S_M0 to S_M4 on one 33x16 multiplier,
//   rounding and output load, and finally S_FIN to close the point.
//   A final point that must be appended adds one beat.
//   run_end marks the last beat caused by a point.
//   The output register holds a beat until m_ready; the sequencer waits on
//   a full output register, so a stalled receiver stalls the block.
//   Reset (aresetn low, synchronous) clears state; time_step returns to 6554.
`default_nettype none
module trajectory_time_resampler_top #(
    parameter int unsigned MAX_SAMPLES_PER_SEGMENT = 63
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ttr_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ttr_pkg::out_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [31:0]   cfg_data
);

    ttr_pkg::cmd_t cmd;
    ttr_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    ttr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ttr_datapath #(
        .MAX_SAMPLES_PER_SEGMENT (MAX_SAMPLES_PER_SEGMENT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous point still in progress");

    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.first_emit, cmd.sample_emit, cmd.final_emit}))
        else $error("more than one result load in a cycle");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.first_emit || cmd.sample_emit || cmd.final_emit) |-> sts.out_free)
        else $error("result loaded over an untaken beat");

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.k_start || cmd.a_start) |-> !sts.div_busy)
        else $error("divider restarted while busy");

endmodule
`default_nettype wire

@@ tb/trajectory_time_resampler_top_test.sv @@
// Self-checking testbench for trajectory_time_resampler_top: directed and random point runs,
// predicted beat by beat by a local fixed-point resampler model, with random idling and stalls.
// Depends on ttr_pkg and the trajectory_time_resampler_top RTL.
`default_nettype none
module trajectory_time_resampler_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_SAMPLES = 63;
    localparam int unsigned LIMIT_CYCLES = 12000000;
    localparam int unsigned SETTLE_CYCLES = 300;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    ttr_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    ttr_pkg::out_t m_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [31:0]   cfg_data = '0;

    trajectory_time_resampler_top #(.MAX_SAMPLES_PER_SEGMENT(MAX_SAMPLES)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    ttr_pkg::in_t  point_queue[$];
    ttr_pkg::out_t sample_queue[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_cycles = 0;
    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned points_in = 0;
    int unsigned beats_out = 0;
    int unsigned clipped_beats = 0;
    bit          s_took = 1'b0;
    bit          cfg_took = 1'b0;

    // resampler model state
    logic [31:0]        step_reg = ttr_pkg::TIME_STEP_RESET;
    bit                 run_started = 1'b0;
    logic [31:0]        last_time = '0;
    logic signed [31:0] last_x = '0;
    logic signed [31:0] last_y = '0;
    logic [32:0]        sample_clk = '0;
    logic signed [31:0] shown_x = '0;
    logic signed [31:0] shown_y = '0;

    function automatic logic signed [31:0] lerp32(logic signed [31:0] a, logic signed [31:0] b,
                                                  logic [63:0] alpha);
        longint      d;
        logic [63:0] mag;
        logic [63:0] r;
        d = longint'(b) - longint'(a);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        r = (mag * alpha + 64'h4000_0000) >> 31;
        return (d < 0) ? a - r[31:0] : a + r[31:0];
    endfunction

    function automatic void resample_point(ttr_pkg::in_t p);
        ttr_pkg::out_t beats[$];
        ttr_pkg::out_t b;
        logic [63:0]   stp;
        logic [63:0]   clk;
        logic [63:0]   k;
        logic [63:0]   emit;
        logic [63:0]   t;
        logic [63:0]   seg;
        logic [63:0]   alpha;
        bit            clip;
        clip = 1'b0;
        if (!run_started) begin
            b = '{sample_x: p.point_x, sample_y: p.point_y, run_end: 1'b0, clipped: 1'b0};
            beats = {beats, b};
            shown_x = p.point_x;
            shown_y = p.point_y;
            sample_clk = {1'b0, p.point_time};
            run_started = 1'b1;
        end else begin
            stp = (step_reg == 0) ? 64'd1 : {32'd0, step_reg};
            clk = {31'd0, sample_clk};
            k = ({32'd0, p.point_time} >= clk) ? ({32'd0, p.point_time} - clk) / stp : 64'd0;
            emit = (k > MAX_SAMPLES) ? 64'(MAX_SAMPLES) : k;
            clip = (k > emit);
            if (p.point_time > last_time) begin
                seg = {32'd0, p.point_time} - {32'd0, last_time};
                for (longint j = 1; j <= longint'(emit); j++) begin
                    t = clk + 64'(j) * stp;
                    if (t < {32'd0, last_time}) t = {32'd0, last_time};
                    alpha = ((t - {32'd0, last_time}) << 31) / seg;
                    b.sample_x = lerp32(last_x, p.point_x, alpha);
                    b.sample_y = lerp32(last_y, p.point_y, alpha);
                    b.run_end = 1'b0;
                    b.clipped = clip;
                    beats = {beats, b};
                    shown_x = b.sample_x;
                    shown_y = b.sample_y;
                end
            end
            sample_clk = 33'(clk + k * stp);
        end
        if (p.final_point) begin
            if (shown_x != p.point_x || shown_y != p.point_y) begin
                b = '{sample_x: p.point_x, sample_y: p.point_y, run_end: 1'b0, clipped: clip};
                beats = {beats, b};
                shown_x = p.point_x;
                shown_y = p.point_y;
            end
            run_started = 1'b0;
        end
        last_time = p.point_time;
        last_x = p.point_x;
        last_y = p.point_y;
        if (beats.size() > 0) beats[beats.size() - 1].run_end = 1'b1;
        sample_queue = {sample_queue, beats};
    endfunction

    // monitor and scoreboard
    always @(posedge aclk) begin
        ttr_pkg::out_t want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d beats still expected", $time, sample_queue.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (aresetn) begin
            s_took = s_valid && s_ready;
            cfg_took = cfg_valid && cfg_ready;
            if (cfg_took) step_reg = cfg_data;
            if (s_took) begin
                points_in++;
                resample_point(s_data);
            end
            if (m_valid && m_ready) begin
                beats_out++;
                if (m_data.clipped) clipped_beats++;
                if (sample_queue.size() == 0) begin
                    errors++;
                    $display("%0t: beat exp none got %h", $time, m_data);
                end else begin
                    want = sample_queue.pop_front();
                    if (m_data.sample_x !== want.sample_x) begin
                        errors++;
                        $display("%0t: sample_x exp %h got %h", $time, want.sample_x,
                                 m_data.sample_x);
                    end
                    if (m_data.sample_y !== want.sample_y) begin
                        errors++;
                        $display("%0t: sample_y exp %h got %h", $time, want.sample_y,
                                 m_data.sample_y);
                    end
                    if (m_data.run_end !== want.run_end) begin
                        errors++;
                        $display("%0t: run_end exp %b got %b", $time, want.run_end,
                                 m_data.run_end);
                    end
                    if (m_data.clipped !== want.clipped) begin
                        errors++;
                        $display("%0t: clipped exp %b got %b", $time, want.clipped,
                                 m_data.clipped);
                    end
                end
            end
        end
    end

    // point driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data <= point_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // beat receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    logic [31:0]        gen_step = ttr_pkg::TIME_STEP_RESET;
    logic [31:0]        gen_t;
    logic signed [31:0] gen_x;
    logic signed [31:0] gen_y;

    task automatic add_point(logic [31:0] t, logic [31:0] x, logic [31:0] y, bit fin);
        ttr_pkg::in_t p;
        p = '{point_time: t, point_x: x, point_y: y, final_point: fin};
        point_queue = {point_queue, p};
    endtask

    task automatic write_step(logic [31:0] value);
        @(negedge aclk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
        gen_step = value;
    endtask

    task automatic drain();
        do @(negedge aclk); while (point_queue.size() > 0 || s_valid || sample_queue.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic gen_run(int npts);
        int unsigned roll;
        logic [63:0] stp;
        stp = (gen_step == 0) ? 64'd1 : {32'd0, gen_step};
        for (int i = 0; i < npts; i++) begin
            roll = $urandom_range(99);
            if (i == 0) begin
                gen_t = $urandom;
            end else if (roll < 3 && stp < 64'h1000_0000) begin
                gen_t = 32'(gen_t + stp * $urandom_range(70, 90));
            end else if (roll < 9) begin
                gen_t = gen_t - $urandom_range(0, 3000);
            end else if (stp < 64'h1000_0000) begin
                gen_t = 32'(gen_t + stp * $urandom_range(0, 4) + $urandom_range(0, 32'(stp - 1)));
            end else begin
                gen_t = $urandom;
            end
            roll = $urandom_range(99);
            if (i == 0 || roll < 50) begin
                gen_x = $urandom;
                gen_y = $urandom;
            end else begin
                gen_x = gen_x + $signed($urandom_range(0, 2000000)) - 1000000;
                gen_y = gen_y + $signed($urandom_range(0, 2000000)) - 1000000;
            end
            add_point(gen_t, gen_x, gen_y, i == npts - 1);
        end
    endtask

    task automatic gen_items(int n);
        int len;
        while (n > 0) begin
            len = $urandom_range(1, 8);
            if (len > n) len = n;
            gen_run(len);
            n -= len;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 69;
        // default step: extremes, repeat/decreasing time, clipping, final append
        add_point(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_point(32'd19662, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_point(32'd19662, 32'd5, -32'sd5, 1'b0);
        add_point(32'd655400, 32'd0, 32'd0, 1'b0);
        add_point(32'd655410, 32'd1, 32'd2, 1'b1);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_point(32'd1000, 32'd10, 32'd10, 1'b0);
        add_point(32'd7554, 32'd20, 32'd20, 1'b1);
        add_point(32'd50, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
        add_point(32'd20, 32'h1234_5678, 32'h8765_4321, 1'b1);
        drain();
        // shrinking the step puts samples before the segment start
        write_step(32'h0001_0000);
        add_point(32'd0, 32'd0, 32'd0, 1'b0);
        add_point(32'd100000, 32'h0010_0000, -32'sh0010_0000, 1'b0);
        drain();
        write_step(32'd1000);
        add_point(32'd200000, 32'h0030_0000, 32'h0003_0000, 1'b1);
        drain();
        write_step(32'd0);
        add_point(32'd0, 32'd0, 32'd0, 1'b0);
        add_point(32'd100, 32'h7FFF_0000, 32'h0000_7FFF, 1'b1);
        drain();
        write_step(32'hFFFF_FFFF);
        gen_items(12);
        drain();
        write_step(32'd6554);
        gen_items(140);
        drain();

        send_idle_pct = 69;
        recv_idle_pct = 7;
        write_step(32'h0001_0000);
        gen_items(110);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_step(32'h0000_0333);
        @(negedge aclk);
        hold_cycles = 600;
        gen_items(100);
        drain();

        $display("%0d points in, %0d beats checked (%0d clipped), %0d field errors",
                 points_in, beats_out, clipped_beats, errors);
        $display("steps covered: zero, one-ish, default, 1.0 s, all-ones; three idling mixes");
        if (errors == 0 && sample_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
